### rtl/stable_priority_queue_assert.svh
// Assertion helpers for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Condition implies property in the same cycle.
`define SPQ_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition implies property in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic       CMD_ENQ  = 1'b0;
  localparam logic       CMD_DEQ  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [7:0]          prio;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

  function automatic logic [TAG_BITS-1:0] tag_store(input logic [15:0] t);
    return TAG_BITS'(t);
  endfunction

  function automatic logic [15:0] tag_load(input logic [TAG_BITS-1:0] t);
    return 16'(t);
  endfunction

endpackage
`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none
module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::entry_t   ins,
  input  wire spq_pkg::entry_t   left,
  input  wire logic              left_ge,
  input  wire spq_pkg::entry_t   right,
  input  wire logic              occupied,
  output spq_pkg::entry_t        ent,
  output logic                   ge
);

  spq_pkg::entry_t ent_next;

  // Occupied entry that stays ahead of the new one (stable on ties).
  assign ge = occupied && (ent.prio >= ins.prio);

  always_comb begin
    ent_next = ent;
    if (ctl.enq) begin
      if (!ge) begin
        ent_next = left_ge ? ins : left;
      end
    end else if (ctl.deq) begin
      ent_next = right;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
`default_nettype wire

### rtl/stable_priority_queue.sv
// Channel  Handshake                 Payload
// cmd      cmd_valid / cmd_ready     command, priority_req, tag
// res      res_valid / res_ready     status, popped_valid, popped_priority,
//                                    popped_tag, occupancy
//
// One beat per cycle while cmd_ready is high: every cell compares with the
// new priority in parallel and shifts in the same cycle, and the result is
// out the cycle after acceptance, in an output register; cmd_ready is low
// only while a result waits and res_ready is low.
// Reset (rst, synchronous) empties the queue and drops any pending result.
`default_nettype none
module stable_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic        command,
  input  wire logic [7:0]  priority_req,
  input  wire logic [15:0] tag,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       status,
  output logic             popped_valid,
  output logic [7:0]       popped_priority,
  output logic [15:0]      popped_tag,
  output logic [4:0]       occupancy
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               cmd_acc;
  logic               full;
  logic               empty;
  logic               do_enq;
  logic               do_deq;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    ins;
  spq_pkg::entry_t    ent [DEPTH];
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   occ;
  logic [1:0]         status_next;

  assign cmd_ready = !res_valid || res_ready;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_enq    = cmd_acc && (command == spq_pkg::CMD_ENQ) && !full;
  assign do_deq    = cmd_acc && (command == spq_pkg::CMD_DEQ) && !empty;
  assign ctl.enq   = do_enq;
  assign ctl.deq   = do_deq;

  assign ins.prio  = priority_req;
  assign ins.tag   = spq_pkg::tag_store(tag);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .ins      (ins),
        .left     (ins),
        .left_ge  (1'b1),
        .right    (ent[1]),
        .occupied (occ[0]),
        .ent      (ent[0]),
        .ge       (ge[0])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .ins      (ins),
        .left     (ent[i-1]),
        .left_ge  (ge[i-1]),
        .right    (ent[i]),
        .occupied (occ[i]),
        .ent      (ent[i]),
        .ge       (ge[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .ins      (ins),
        .left     (ent[i-1]),
        .left_ge  (ge[i-1]),
        .right    (ent[i+1]),
        .occupied (occ[i]),
        .ent      (ent[i]),
        .ge       (ge[i])
      );
    end
  end

  always_comb begin
    count_next  = count;
    status_next = spq_pkg::ST_OK;
    if (do_enq) begin
      count_next = count + 1'b1;
    end else if (do_deq) begin
      count_next = count - 1'b1;
    end
    if (command == spq_pkg::CMD_ENQ) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      status_next = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd_acc) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      status          <= status_next;
      popped_valid    <= do_deq;
      popped_priority <= do_deq ? ent[0].prio : 8'd0;
      popped_tag      <= do_deq ? spq_pkg::tag_load(ent[0].tag) : 16'd0;
      occupancy       <= 5'(count_next);
    end
  end

  `include "stable_priority_queue_assert.svh"

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_enq_inc, do_enq, count == $past(count) + 1'b1, "enqueue count")
  `SPQ_ASSERT_NEXT(a_acc_res, cmd_acc, res_valid, "accepted beat without result")
  `SPQ_ASSERT_NEXT(a_head_order, do_deq && (count > CNT_W'(1)), popped_priority >= ent[0].prio, "head order")
  `SPQ_ASSERT_NOW(a_pop_ok, res_valid && popped_valid, status == spq_pkg::ST_OK, "pop status")

endmodule
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  prio;
    logic [15:0] tag;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        popped_valid;
    logic [7:0]  popped_priority;
    logic [15:0] popped_tag;
    logic [4:0]  occupancy;
  } queue_result_t;

  localparam int DEPTH       = spq_pkg::DEPTH;
  localparam int TAG_BITS    = spq_pkg::TAG_BITS;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT     = 700;
  localparam logic [16*8-1:0] SEED_PRIOS = {
    8'd255, 8'd0,   8'd128, 8'd255, 8'd0,  8'd1,  8'd254, 8'd128,
    8'd7,   8'd255, 8'd0,   8'd64,  8'd64, 8'd200, 8'd3,  8'd255
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic        command = spq_pkg::CMD_ENQ;
  logic [7:0]  priority_req = 8'd0;
  logic [15:0] tag = 16'd0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [1:0]  status;
  logic        popped_valid;
  logic [7:0]  popped_priority;
  logic [15:0] popped_tag;
  logic [4:0]  occupancy;

  stable_priority_queue dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .priority_req(priority_req), .tag(tag),
    .res_valid(res_valid), .res_ready(res_ready),
    .status(status), .popped_valid(popped_valid),
    .popped_priority(popped_priority), .popped_tag(popped_tag),
    .occupancy(occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_beat_t     cmd_backlog[$];
  queue_result_t pending_results[$];

  spq_pkg::entry_t shadow_entries [DEPTH];
  int unsigned     shadow_count = 0;

  int unsigned cmds_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_enq = 0, n_full = 0, n_pop = 0, n_empty = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Sorted-list queue: insert behind all entries of priority >= new one.
  function automatic queue_result_t apply_command(cmd_beat_t b);
    queue_result_t r;
    int unsigned   pos;
    r = '0;
    if (b.cmd == spq_pkg::CMD_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_entries[pos].prio >= b.prio) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos].prio = b.prio;
        shadow_entries[pos].tag  = TAG_BITS'(b.tag);
        shadow_count++;
        r.status = spq_pkg::ST_OK;
        n_enq++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.status          = spq_pkg::ST_OK;
        r.popped_valid    = 1'b1;
        r.popped_priority = shadow_entries[0].prio;
        r.popped_tag      = 16'(shadow_entries[0].tag);
        for (int i = 1; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
        shadow_count--;
        n_pop++;
      end
    end
    r.occupancy = 5'(shadow_count);
    return r;
  endfunction

  // no gaps on either side while commands 400..599 go through
  function automatic bit take_gap();
    if (cmds_accepted >= 400 && cmds_accepted < 600) return 1'b0;
    return $urandom_range(99) < 23;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("MISMATCH result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic queue_beat(logic c, logic [7:0] p, logic [15:0] t);
    cmd_beat_t b;
    b.cmd  = c;
    b.prio = p;
    b.tag  = t;
    cmd_backlog.push_back(b);
  endtask

  // driver
  always @(posedge clk) begin : drive_cmd
    cmd_beat_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        nxt.cmd  = command;
        nxt.prio = priority_req;
        nxt.tag  = tag;
        pending_results.push_back(apply_command(nxt));
        cmds_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (cmd_backlog.size() != 0 && !take_gap()) begin
          nxt = cmd_backlog.pop_front();
          command      <= nxt.cmd;
          priority_req <= nxt.prio;
          tag          <= nxt.tag;
          cmd_valid    <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin : watch_res
    queue_result_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected beat, status", status, 0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (popped_valid !== want.popped_valid)
            flag_mismatch("popped_valid", popped_valid, want.popped_valid);
          if (popped_priority !== want.popped_priority)
            flag_mismatch("popped_priority", popped_priority, want.popped_priority);
          if (popped_tag !== want.popped_tag)
            flag_mismatch("popped_tag", popped_tag, want.popped_tag);
          if (occupancy !== want.occupancy)
            flag_mismatch("occupancy", occupancy, want.occupancy);
        end
        results_seen++;
      end
      if (!hold_done && cmds_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim
    int unsigned burst, enq_pct, mode;
    logic        c;
    logic [7:0]  p;

    // directed: empty pop, fill with ties and extremes, refused push, drain two, push two
    queue_beat(spq_pkg::CMD_DEQ, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 16; i++)
      queue_beat(spq_pkg::CMD_ENQ, SEED_PRIOS[i*8 +: 8],
                 (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom));
    queue_beat(spq_pkg::CMD_ENQ, 8'hFF, 16'hFFFF);
    queue_beat(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);
    queue_beat(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);
    queue_beat(spq_pkg::CMD_ENQ, 8'd255, 16'h5A5A);
    queue_beat(spq_pkg::CMD_ENQ, 8'd0, 16'hA5A5);

    // random bursts that push the queue toward full, toward empty or keep it balanced
    while (cmd_backlog.size() < 1100) begin
      burst = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      mode = $urandom_range(2);
      repeat (burst) begin
        c = ($urandom_range(99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
        case (mode)
          0: p = 8'($urandom_range(3));
          1: p = 8'($urandom);
          default: p = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        queue_beat(c, p, 16'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || cmd_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (pending_results.size() != 0)
      flag_mismatch("results never arrived, count", 0, pending_results.size());
    $display("ran %0d commands, checked %0d results, %0d mismatches",
             cmds_accepted, results_seen, mismatches);
    $display("pushed %0d, refused full %0d, popped %0d, popped empty %0d",
             n_enq, n_full, n_pop, n_empty);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
